// File: src/lsi_pkg.sv
// ----------------------------------------------------------------------------
// lsi_pkg
// Widths, constants and stage types shared by the segment intersection pipe.
// ----------------------------------------------------------------------------
package lsi_pkg;

    localparam int FIELD_W   = 16;
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS = 16;
    localparam int OUT_BITS  = 24;
    localparam int PT_FRAC   = 8;
    localparam int TOL_W     = 16;

    localparam int DIFF_W    = COORD_BITS + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int NUM_W     = PROD_W + 1;
    localparam int SH_W      = OUT_BITS - FRAC_BITS;
    localparam int RAT_W     = OUT_BITS + 2;
    localparam int RC_W      = FRAC_BITS + 3;
    localparam int PX_W      = DIFF_W + RC_W;
    localparam int SUM_W     = PX_W + 1;
    localparam int DIV_STEPS = OUT_BITS;

    localparam int FRONT_STAGES = 4;
    localparam int BACK_STAGES  = 3;
    localparam int NUM_STAGES   = FRONT_STAGES + DIV_STEPS + BACK_STAGES;

    localparam int S_DATA_W = 8 * FIELD_W;
    localparam int M_DATA_W = 4 * OUT_BITS;
    localparam int M_USER_W = 3;

    typedef struct packed {
        logic                    par;
        logic                    coin;
        logic signed [DIFF_W-1:0] dxa;
        logic signed [DIFF_W-1:0] dya;
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
    } lsi_side_t;

    typedef struct packed {
        logic               neg;
        logic               ovf;
        logic [NUM_W-1:0]   rem;
        logic [OUT_BITS-1:0] qs;
    } lsi_lane_t;

    typedef struct packed {
        lsi_side_t        side;
        logic [NUM_W-1:0] ud;
        lsi_lane_t        a;
        lsi_lane_t        b;
    } lsi_dstage_t;

    typedef struct packed {
        logic                      hit;
        logic                      par;
        logic                      coin;
        logic signed [OUT_BITS-1:0] ratio_a;
        logic signed [OUT_BITS-1:0] ratio_b;
        logic signed [OUT_BITS-1:0] cross_x;
        logic signed [OUT_BITS-1:0] cross_y;
    } lsi_res_t;

    // one restoring division step: bring in the next dividend bit
    function automatic lsi_lane_t lane_step(lsi_lane_t l, logic [NUM_W-1:0] ud);
        logic [NUM_W:0] t;
        logic           ge;
        lsi_lane_t      o;
        t  = {l.rem, l.qs[OUT_BITS-1]};
        ge = (t >= {1'b0, ud});
        o       = l;
        o.rem   = ge ? NUM_W'(t - {1'b0, ud}) : NUM_W'(t);
        o.qs    = {l.qs[OUT_BITS-2:0], ge};
        return o;
    endfunction

endpackage

// File: src/lsi_front.sv
// ----------------------------------------------------------------------------
// lsi_front
// Differences, cross products, numerators/denominator and divider setup.
// ----------------------------------------------------------------------------
module lsi_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [lsi_pkg::FRONT_STAGES-1:0] en,
    input  logic                          v_in,
    input  logic [lsi_pkg::S_DATA_W-1:0]  s_data,
    output logic [lsi_pkg::FRONT_STAGES-1:0] valid,
    output lsi_pkg::lsi_dstage_t          d_out
);
    import lsi_pkg::*;

    logic [FRONT_STAGES-1:0] v_reg;

    logic signed [DIFF_W-1:0] dxa_reg, dya_reg, dxb_reg, dyb_reg, ox_reg, oy_reg;
    logic signed [COORD_BITS-1:0] x1_s1_reg, y1_s1_reg;
    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    lsi_side_t side2_reg;
    logic signed [NUM_W-1:0] na_reg, nb_reg, den_reg;
    lsi_side_t side3_reg;
    lsi_dstage_t d_reg, d_next;

    logic signed [DIFF_W-1:0] c [8];
    logic [NUM_W-1:0] ua, ub, ud;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            c[i] = $signed({s_data[i*FIELD_W + FIELD_W-1], s_data[i*FIELD_W +: FIELD_W]});
        end
    end

    always_comb begin
        ua = na_reg[NUM_W-1] ? NUM_W'(-na_reg) : NUM_W'(na_reg);
        ub = nb_reg[NUM_W-1] ? NUM_W'(-nb_reg) : NUM_W'(nb_reg);
        ud = den_reg[NUM_W-1] ? NUM_W'(-den_reg) : NUM_W'(den_reg);
        d_next.side      = side3_reg;
        d_next.side.par  = (den_reg == '0);
        d_next.side.coin = (den_reg == '0) && (na_reg == '0) && (nb_reg == '0);
        d_next.ud        = ud;
        d_next.a.neg = na_reg[NUM_W-1] ^ den_reg[NUM_W-1];
        d_next.b.neg = nb_reg[NUM_W-1] ^ den_reg[NUM_W-1];
        // quotient needs more than OUT_BITS bits
        d_next.a.ovf = ({{SH_W{1'b0}}, ua} >= {ud, {SH_W{1'b0}}});
        d_next.b.ovf = ({{SH_W{1'b0}}, ub} >= {ud, {SH_W{1'b0}}});
        d_next.a.rem = ua >> SH_W;
        d_next.b.rem = ub >> SH_W;
        d_next.a.qs  = {ua[SH_W-1:0], {FRAC_BITS{1'b0}}};
        d_next.b.qs  = {ub[SH_W-1:0], {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= v_in;
            for (int i = 1; i < FRONT_STAGES; i++) begin
                if (en[i]) v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dxa_reg   <= c[2] - c[0];
            dya_reg   <= c[3] - c[1];
            dxb_reg   <= c[6] - c[4];
            dyb_reg   <= c[7] - c[5];
            ox_reg    <= c[0] - c[4];
            oy_reg    <= c[1] - c[5];
            x1_s1_reg <= COORD_BITS'(c[0]);
            y1_s1_reg <= COORD_BITS'(c[1]);
        end
        if (en[1]) begin
            p0_reg <= dxb_reg * oy_reg;
            p1_reg <= dyb_reg * ox_reg;
            p2_reg <= dxa_reg * oy_reg;
            p3_reg <= dya_reg * ox_reg;
            p4_reg <= dyb_reg * dxa_reg;
            p5_reg <= dxb_reg * dya_reg;
            side2_reg <= '{par: 1'b0, coin: 1'b0, dxa: dxa_reg, dya: dya_reg,
                           x1: x1_s1_reg, y1: y1_s1_reg};
        end
        if (en[2]) begin
            na_reg    <= NUM_W'(p0_reg) - NUM_W'(p1_reg);
            nb_reg    <= NUM_W'(p2_reg) - NUM_W'(p3_reg);
            den_reg   <= NUM_W'(p4_reg) - NUM_W'(p5_reg);
            side3_reg <= side2_reg;
        end
        if (en[3]) begin
            d_reg <= d_next;
        end
    end

    assign valid = v_reg;
    assign d_out = d_reg;

endmodule

// File: src/lsi_div_step.sv
// ----------------------------------------------------------------------------
// lsi_div_step
// One registered restoring-division step for both ratios.
// ----------------------------------------------------------------------------
module lsi_div_step (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 v_in,
    input  lsi_pkg::lsi_dstage_t d_in,
    output logic                 v_out,
    output lsi_pkg::lsi_dstage_t d_out
);
    import lsi_pkg::*;

    logic        v_reg;
    lsi_dstage_t d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg.side <= d_in.side;
            d_reg.ud   <= d_in.ud;
            d_reg.a    <= lane_step(d_in.a, d_in.ud);
            d_reg.b    <= lane_step(d_in.b, d_in.ud);
        end
    end

    assign v_out = v_reg;
    assign d_out = d_reg;

endmodule

// File: src/lsi_back.sv
// ----------------------------------------------------------------------------
// lsi_back
// Signed ratios, window test and saturation, then the crossing point.
// ----------------------------------------------------------------------------
module lsi_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [lsi_pkg::BACK_STAGES-1:0]  en,
    input  logic                             v_in,
    input  lsi_pkg::lsi_dstage_t             d_in,
    input  logic [lsi_pkg::TOL_W-1:0]        tol,
    output logic [lsi_pkg::BACK_STAGES-1:0]  valid,
    output lsi_pkg::lsi_res_t                res
);
    import lsi_pkg::*;

    localparam logic signed [RAT_W-1:0] RMAX = (RAT_W'(1) << (OUT_BITS-1)) - RAT_W'(1);
    localparam logic signed [RAT_W-1:0] RMIN = -(RAT_W'(1) << (OUT_BITS-1));
    localparam logic signed [SUM_W-1:0] SMAX = (SUM_W'(1) << (OUT_BITS-1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SMIN = -(SUM_W'(1) << (OUT_BITS-1));
    localparam logic signed [OUT_BITS-1:0] OMAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0] OMIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    logic [BACK_STAGES-1:0] v_reg;

    lsi_res_t r1_reg, r1_next, r2_reg, r3_reg, r3_next;
    logic signed [RC_W-1:0] ra_reg;
    logic signed [DIFF_W-1:0] dxa_reg, dya_reg;
    logic signed [COORD_BITS-1:0] x1_reg, y1_reg, x1_m_reg, y1_m_reg;
    logic signed [PX_W-1:0] px_reg, py_reg;

    logic signed [RAT_W-1:0] rat_a, rat_b;
    logic win_a, win_b;

    function automatic logic signed [RAT_W-1:0] to_ratio(lsi_lane_t l);
        logic signed [RAT_W-1:0] r;
        r = $signed({2'b00, l.qs});
        if (l.neg) r = -r - RAT_W'(l.rem != '0);
        return r;
    endfunction

    function automatic logic in_win(lsi_lane_t l, logic signed [RAT_W-1:0] r,
                                    logic [TOL_W-1:0] t);
        logic signed [RAT_W-1:0] lo;
        logic signed [RAT_W-1:0] hi;
        lo = -$signed({{(RAT_W-TOL_W){1'b0}}, t});
        hi = $signed((RAT_W'(1) << FRAC_BITS) + {{(RAT_W-TOL_W){1'b0}}, t});
        return !l.ovf && (r >= lo) && ((r < hi) || ((r == hi) && (l.rem == '0)));
    endfunction

    function automatic logic signed [OUT_BITS-1:0] sat_ratio(lsi_lane_t l,
                                                            logic signed [RAT_W-1:0] r);
        if (l.ovf)     return l.neg ? OMIN : OMAX;
        if (r > RMAX)  return OMAX;
        if (r < RMIN)  return OMIN;
        return OUT_BITS'(r);
    endfunction

    function automatic logic signed [OUT_BITS-1:0] point(logic signed [COORD_BITS-1:0] b,
                                                        logic signed [PX_W-1:0] p);
        logic signed [SUM_W-1:0] s;
        logic signed [PX_W-1:0]  q;
        q = p >>> (FRAC_BITS - PT_FRAC);
        s = SUM_W'($signed({b, {PT_FRAC{1'b0}}})) + SUM_W'(q);
        if (s > SMAX) return OMAX;
        if (s < SMIN) return OMIN;
        return OUT_BITS'(s);
    endfunction

    always_comb begin
        rat_a = to_ratio(d_in.a);
        rat_b = to_ratio(d_in.b);
        win_a = in_win(d_in.a, rat_a, tol);
        win_b = in_win(d_in.b, rat_b, tol);
        r1_next.par     = d_in.side.par;
        r1_next.coin    = d_in.side.coin;
        r1_next.hit     = !d_in.side.par && win_a && win_b;
        r1_next.ratio_a = d_in.side.par ? '0 : sat_ratio(d_in.a, rat_a);
        r1_next.ratio_b = d_in.side.par ? '0 : sat_ratio(d_in.b, rat_b);
        r1_next.cross_x = '0;
        r1_next.cross_y = '0;
    end

    always_comb begin
        r3_next         = r2_reg;
        r3_next.cross_x = r2_reg.hit ? point(x1_m_reg, px_reg) : '0;
        r3_next.cross_y = r2_reg.hit ? point(y1_m_reg, py_reg) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= v_in;
            for (int i = 1; i < BACK_STAGES; i++) begin
                if (en[i]) v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            r1_reg  <= r1_next;
            // ratio a fits in RC_W bits whenever there is a hit
            ra_reg  <= RC_W'(rat_a);
            dxa_reg <= d_in.side.dxa;
            dya_reg <= d_in.side.dya;
            x1_reg  <= d_in.side.x1;
            y1_reg  <= d_in.side.y1;
        end
        if (en[1]) begin
            r2_reg   <= r1_reg;
            px_reg   <= dxa_reg * ra_reg;
            py_reg   <= dya_reg * ra_reg;
            x1_m_reg <= x1_reg;
            y1_m_reg <= y1_reg;
        end
        if (en[2]) begin
            r3_reg <= r3_next;
        end
    end

    assign valid = v_reg;
    assign res   = r3_reg;

endmodule

// File: src/line_segment_intersection.sv
// ----------------------------------------------------------------------------
// line_segment_intersection
// 2D segment pair intersection: ratios, hit test, crossing point.
// ----------------------------------------------------------------------------
// The path from request accept to result runs through 4 setup stages,
//   24 restoring division steps and 3 output stages
// throughput: one request per cycle; every stage holds under backpressure
//   and empty stages fill in, so the input stalls only once all 31 stages hold
// reset: aresetn synchronous active low, clears all stage valids and sets
//   tolerance to 0
module line_segment_intersection (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [lsi_pkg::TOL_W-1:0]        cfg_wdata,   // tolerance
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [lsi_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // cross_x, cross_y, ratio_a, ratio_b
    output logic [lsi_pkg::M_DATA_W-1:0]     m_tdata,
    // hit, is_parallel, is_coincident
    output logic [lsi_pkg::M_USER_W-1:0]     m_tuser
);
    import lsi_pkg::*;

    logic [TOL_W-1:0]      tol_reg;
    logic [NUM_STAGES-1:0] v;
    logic [NUM_STAGES-1:0] en;
    lsi_dstage_t           dd [DIV_STEPS+1];
    lsi_res_t              res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
        end else if (cfg_we) begin
            tol_reg <= cfg_wdata;
        end
    end

    // a stage loads when it is empty or the next one loads
    assign en[NUM_STAGES-1] = !v[NUM_STAGES-1] || m_tready;
    for (genvar i = 0; i < NUM_STAGES-1; i++) begin : g_en
        assign en[i] = !v[i] || en[i+1];
    end

    lsi_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en[FRONT_STAGES-1:0]),
        .v_in    (s_tvalid),
        .s_data  (s_tdata),
        .valid   (v[FRONT_STAGES-1:0]),
        .d_out   (dd[0])
    );

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        lsi_div_step u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en[FRONT_STAGES+k]),
            .v_in    (v[FRONT_STAGES+k-1]),
            .d_in    (dd[k]),
            .v_out   (v[FRONT_STAGES+k]),
            .d_out   (dd[k+1])
        );
    end

    lsi_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en[NUM_STAGES-1 -: BACK_STAGES]),
        .v_in    (v[FRONT_STAGES+DIV_STEPS-1]),
        .d_in    (dd[DIV_STEPS]),
        .tol     (tol_reg),
        .valid   (v[NUM_STAGES-1 -: BACK_STAGES]),
        .res     (res)
    );

    assign s_tready = en[0];
    assign m_tvalid = v[NUM_STAGES-1];
    assign m_tdata  = {res.ratio_b, res.ratio_a, res.cross_y, res.cross_x};
    assign m_tuser  = {res.coin, res.par, res.hit};

endmodule
